FILE: hw/rtl/sorted_table_binary_search_assert.svh
// Assertion macros for the sorted table binary search block.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// Same-cycle implication.
`define STBS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define STBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/stbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
package stbs_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int KEY_WIDTH_DEFAULT   = 32;

   localparam int IDX_W     = 10;
   localparam int POS_W     = IDX_W + 1;
   localparam int FIELD_KEY_W = 32;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_ACCESS,
      ST_COMPARE
   } stbs_state_type;

endpackage

FILE: hw/rtl/sorted_table_binary_search.sv
// Sorted key table with an iterative binary search over a registered-read memory.
//
//   channel   ports                          handshake
//   request   req_*                          taken when start & !busy
//   response  rsp_*                          rsp_strobe, one cycle, no backpressure
//
// Search: one probe per cycle at a power-of-two or 1024+ depth (memory read then key
// compare), busy while probing, at most 11 probes for a 1024-entry range; the response
// is registered from the last compare. An empty range responds in the cycle after the
// request without going busy. Write at such a depth: stored at the request edge, busy
// stays low. Other depths (below 1024, not a power of two) pass each probe and write
// through a reciprocal multiply, then a subtract reducing the index, then the memory access.
// Reset clears control only; the table is undefined until written.
// The receiver cannot stall; start is ignored while busy.
`include "sorted_table_binary_search_assert.svh"

module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT,
   parameter int KEY_WIDTH   = stbs_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic [stbs_pkg::IDX_W-1:0]        req_entry_index,
   input  logic [stbs_pkg::FIELD_KEY_W-1:0]  req_entry_key,
   input  logic [stbs_pkg::FIELD_KEY_W-1:0]  req_search_key,
   input  logic [stbs_pkg::IDX_W-1:0]        req_range_low,
   input  logic [stbs_pkg::IDX_W-1:0]        req_range_high,
   input  logic                              req_descending,
   output logic                              rsp_strobe,
   output logic                              rsp_found,
   output logic [stbs_pkg::POS_W-1:0]        rsp_position,
   output logic                              rsp_below_range
);

   localparam int IDX_W    = stbs_pkg::IDX_W;
   localparam int POS_W    = stbs_pkg::POS_W;
   localparam int FKEY_W   = stbs_pkg::FIELD_KEY_W;
   localparam int ADDR_W   = $clog2(TABLE_DEPTH);
   localparam bit IS_POW2  = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
   localparam bit DIRECT   = IS_POW2 || (TABLE_DEPTH >= (1 << IDX_W));
   localparam int STEP_W   = 1;
   localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(1);
   localparam int RCP_SH   = IDX_W + ADDR_W;
   localparam int RCP_W    = IDX_W + 1;
   localparam int PROD_W   = IDX_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP =
      RCP_W'(((1 << RCP_SH) + TABLE_DEPTH - 1) / TABLE_DEPTH);

   function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] x);
      logic [IDX_W+ADDR_W-1:0] w;
      w = {{ADDR_W{1'b0}}, x};
      return w[ADDR_W-1:0];
   endfunction

   function automatic logic [KEY_WIDTH-1:0] key_fit(input logic [FKEY_W-1:0] x);
      logic [FKEY_W+KEY_WIDTH-1:0] w;
      w = {{KEY_WIDTH{1'b0}}, x};
      return w[KEY_WIDTH-1:0];
   endfunction

   logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];

   stbs_pkg::stbs_state_type state_ff, state_in;
   logic [IDX_W:0]        l_ff, l_in;
   logic [IDX_W-1:0]      r_ff, r_in;
   logic [IDX_W-1:0]      m_ff, m_in;
   logic [POS_W-1:0]      fit_ff, fit_in;
   logic [KEY_WIDTH-1:0]  key_ff, key_in;
   logic                  desc_ff, desc_in;
   logic                  op_ff, op_in;
   logic [KEY_WIDTH-1:0]  wkey_ff, wkey_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [IDX_W-1:0]      quot_ff, quot_in;
   logic [KEY_WIDTH-1:0]  rd_data_ff;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]      rsp_position_ff, rsp_position_in;
   logic                  rsp_below_ff, rsp_below_in;

   logic                  rd_en, wr_en;
   logic [ADDR_W-1:0]     rd_addr, wr_addr;
   logic [KEY_WIDTH-1:0]  wr_data;

   logic [IDX_W-1:0]      span_first, mid_first;
   logic [PROD_W-1:0]     quot_prod;
   logic [IDX_W-1:0]      quot_calc, quot_back;
   logic                  k_eq, k_gt, k_lt;
   logic [IDX_W:0]        l_nx;
   logic [IDX_W-1:0]      r_nx, span_nx, mid_nx;
   logic [POS_W-1:0]      fit_nx;
   logic                  stop_nx, found_nx, below_nx;

   assign span_first = req_range_high - req_range_low;
   assign mid_first  = req_range_low + (span_first >> 1);

   // index / depth by reciprocal, exact for every 10-bit index
   assign quot_prod = PROD_W'(addr_ff) * PROD_W'(RCP);
   assign quot_calc = IDX_W'(quot_prod >> RCP_SH);
   assign quot_back = IDX_W'(quot_ff * TABLE_DEPTH);

   assign k_eq = rd_data_ff == key_ff;
   assign k_gt = rd_data_ff > key_ff;
   assign k_lt = !k_eq && !k_gt;

   always_comb begin
      l_nx     = l_ff;
      r_nx     = r_ff;
      fit_nx   = fit_ff;
      stop_nx  = 1'b0;
      found_nx = 1'b0;
      below_nx = 1'b0;
      if (k_eq) begin
         found_nx = 1'b1;
         stop_nx  = 1'b1;
         fit_nx   = {1'b0, m_ff};
      end else if (!desc_ff) begin
         if (k_gt) begin
            if (m_ff == '0) begin
               below_nx = 1'b1;
               stop_nx  = 1'b1;
               fit_nx   = '0;
            end else begin
               r_nx   = m_ff - 1'b1;
               fit_nx = {1'b0, m_ff - 1'b1};
            end
         end else begin
            l_nx = {1'b0, m_ff} + 1'b1;
         end
      end else begin
         if (k_lt) begin
            if (m_ff == '0) begin
               stop_nx = 1'b1;
            end else begin
               r_nx = m_ff - 1'b1;
            end
         end else begin
            l_nx   = {1'b0, m_ff} + 1'b1;
            fit_nx = {1'b0, m_ff} + 1'b1;
         end
      end
   end

   assign span_nx = r_nx - l_nx[IDX_W-1:0];
   assign mid_nx  = l_nx[IDX_W-1:0] + (span_nx >> 1);

   always_comb begin
      state_in        = state_ff;
      l_in            = l_ff;
      r_in            = r_ff;
      m_in            = m_ff;
      fit_in          = fit_ff;
      key_in          = key_ff;
      desc_in         = desc_ff;
      op_in           = op_ff;
      wkey_in         = wkey_ff;
      addr_in         = addr_ff;
      step_in         = step_ff;
      quot_in         = quot_ff;
      rsp_strobe_in   = 1'b0;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      rsp_below_in    = rsp_below_ff;
      rd_en           = 1'b0;
      rd_addr         = to_addr(addr_ff);
      wr_en           = 1'b0;
      wr_addr         = to_addr(addr_ff);
      wr_data         = wkey_ff;
      case (state_ff)
         stbs_pkg::ST_IDLE: begin
            if (start) begin
               if (req_type == stbs_pkg::REQ_WRITE) begin
                  if (DIRECT) begin
                     wr_en   = 1'b1;
                     wr_addr = to_addr(req_entry_index);
                     wr_data = key_fit(req_entry_key);
                  end else begin
                     op_in    = stbs_pkg::REQ_WRITE;
                     wkey_in  = key_fit(req_entry_key);
                     addr_in  = req_entry_index;
                     step_in  = STEP_TOP;
                     state_in = stbs_pkg::ST_REDUCE;
                  end
               end else begin
                  op_in   = stbs_pkg::REQ_SEARCH;
                  key_in  = key_fit(req_search_key);
                  desc_in = req_descending;
                  l_in    = {1'b0, req_range_low};
                  r_in    = req_range_high;
                  fit_in  = {1'b0, req_range_high} + 1'b1;
                  if (req_range_low > req_range_high) begin
                     rsp_strobe_in   = 1'b1;
                     rsp_found_in    = 1'b0;
                     rsp_position_in = {1'b0, req_range_high} + 1'b1;
                     rsp_below_in    = 1'b0;
                  end else begin
                     m_in = mid_first;
                     if (DIRECT) begin
                        rd_en    = 1'b1;
                        rd_addr  = to_addr(mid_first);
                        state_in = stbs_pkg::ST_COMPARE;
                     end else begin
                        addr_in  = mid_first;
                        step_in  = STEP_TOP;
                        state_in = stbs_pkg::ST_REDUCE;
                     end
                  end
               end
            end
         end
         stbs_pkg::ST_REDUCE: begin
            if (step_ff != '0) begin
               quot_in = quot_calc;
            end else begin
               addr_in  = addr_ff - quot_back;
               state_in = stbs_pkg::ST_ACCESS;
            end
            step_in = step_ff - 1'b1;
         end
         stbs_pkg::ST_ACCESS: begin
            if (op_ff == stbs_pkg::REQ_WRITE) begin
               wr_en    = 1'b1;
               state_in = stbs_pkg::ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = stbs_pkg::ST_COMPARE;
            end
         end
         stbs_pkg::ST_COMPARE: begin
            l_in   = l_nx;
            r_in   = r_nx;
            fit_in = fit_nx;
            if (stop_nx || (l_nx > {1'b0, r_nx})) begin
               rsp_strobe_in   = 1'b1;
               rsp_found_in    = found_nx;
               rsp_position_in = fit_nx;
               rsp_below_in    = below_nx;
               state_in        = stbs_pkg::ST_IDLE;
            end else begin
               m_in = mid_nx;
               if (DIRECT) begin
                  rd_en   = 1'b1;
                  rd_addr = to_addr(mid_nx);
               end else begin
                  addr_in  = mid_nx;
                  step_in  = STEP_TOP;
                  state_in = stbs_pkg::ST_REDUCE;
               end
            end
         end
         default: begin
            state_in = stbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= stbs_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff            <= l_in;
      r_ff            <= r_in;
      m_ff            <= m_in;
      fit_ff          <= fit_in;
      key_ff          <= key_in;
      desc_ff         <= desc_in;
      op_ff           <= op_in;
      wkey_ff         <= wkey_in;
      addr_ff         <= addr_in;
      step_ff         <= step_in;
      quot_ff         <= quot_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_below_ff    <= rsp_below_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign busy            = state_ff != stbs_pkg::ST_IDLE;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_below_range = rsp_below_ff;

   `STBS_ASSERT_NOW(a_probe_in_range, clock, reset, state_ff == stbs_pkg::ST_COMPARE, l_ff <= {1'b0, r_ff}, "probe outside bounds")
   `STBS_ASSERT_NOW(a_below_clean, clock, reset, rsp_strobe_ff && rsp_below_ff, !rsp_found_ff && (rsp_position_ff == '0), "below-range response carries a result")
   `STBS_ASSERT_NOW(a_rsp_has_cause, clock, reset, rsp_strobe_ff, $past(state_ff != stbs_pkg::ST_IDLE) || $past(start), "response without request")
   `STBS_ASSERT_NOW(a_found_in_table, clock, reset, rsp_strobe_ff && rsp_found_ff, !rsp_position_ff[POS_W-1], "match position out of range")

endmodule
